// ===== hw/rtl/sle_pkg.sv =====
`timescale 1ns / 1ps

package sle_pkg;

    localparam logic [3:0] OP_CLEAR  = 4'd0;
    localparam logic [3:0] OP_GET    = 4'd1;
    localparam logic [3:0] OP_LOCATE = 4'd2;
    localparam logic [3:0] OP_PRIOR  = 4'd3;
    localparam logic [3:0] OP_NEXT   = 4'd4;
    localparam logic [3:0] OP_INSERT = 4'd5;
    localparam logic [3:0] OP_DELETE = 4'd6;
    localparam logic [3:0] OP_SORT   = 4'd7;
    localparam logic [3:0] OP_MAXSUB = 4'd8;
    localparam logic [3:0] OP_COUNT  = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int RV_W = 40;

    typedef enum logic [4:0] {
        SL_IDLE, SL_DISPATCH, SL_GET_WAIT, SL_SCAN_RD, SL_SCAN_CMP,
        SL_INS_CHK, SL_INS_WR, SL_DEL_RES, SL_DEL_CHK, SL_DEL_WR,
        SL_SORT_CHK, SL_SORT_RD1, SL_SORT_CMP, SL_SORT_WR,
        SL_MAX_INIT, SL_MAX_RD, SL_MAX_STEP,
        SL_CNT_OUTER, SL_CNT_RD, SL_CNT_ADD, SL_DONE
    } state_t;

    typedef enum logic [3:0] {
        CNT_HOLD, CNT_ZERO, CNT_ONE, CNT_INC, CNT_DEC,
        CNT_N, CNT_N_M1, CNT_POS_M1, CNT_I
    } cnt_op_t;

    typedef enum logic [2:0] {
        RA_ZERO, RA_I, RA_I_M1, RA_I_P1, RA_J, RA_J_M1, RA_J_P1, RA_POS_M1
    } raddr_sel_t;

    typedef enum logic [1:0] { WA_J, WA_J_P1, WA_POS_M1 } waddr_sel_t;
    typedef enum logic [1:0] { WD_RDATA, WD_TMP, WD_VAL } wdata_sel_t;

    typedef enum logic [2:0] {
        AR_NONE, AR_K_INIT, AR_K_STEP, AR_SUM_CLR, AR_SUM_ADD, AR_CNT_CLR
    } arith_op_t;

    typedef enum logic [1:0] { LEN_HOLD, LEN_ZERO, LEN_INC, LEN_DEC } len_op_t;
    typedef enum logic [1:0] { RV_RDATA, RV_BEST, RV_CNT } rv_sel_t;

    typedef struct packed {
        logic       load_cmd;
        cnt_op_t    i_op;
        cnt_op_t    j_op;
        logic       rd_en;
        raddr_sel_t ra_sel;
        logic       wr_en;
        waddr_sel_t wa_sel;
        wdata_sel_t wd_sel;
        logic       tmp_ld;
        arith_op_t  ar_op;
        len_op_t    len_op;
        logic       st_ld;
        logic [1:0] st_code;
        logic       rv_ld;
        rv_sel_t    rv_sel;
        logic       rp_ld;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic [3:0] op;
        logic       get_ok;
        logic       ins_ok;
        logic       full;
        logic       empty;
        logic       i_lt_n;
        logic       i_zero;
        logic       i_p1_lt_n;
        logic       j_ge_pos;
        logic       j_lt_i;
        logic       j_lt_n;
        logic       j_p1_lt_n;
        logic       match;
        logic       swap;
    } flags_t;

endpackage

// ===== hw/rtl/sle_datapath.sv =====
`timescale 1ns / 1ps

module sle_datapath #(
    parameter int CAPACITY = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sle_pkg::cmd_t       cmd,
    output sle_pkg::flags_t     flags,
    input  logic [39:0]         s_tdata,   // position, value
    input  logic [3:0]          s_tuser,   // opcode
    output logic [55:0]         m_tdata,   // result_value, result_position, list_size
    output logic [1:0]          m_tuser    // status
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMPW  = ((CW > 8) ? CW : 8) + 1;
    localparam int SUM_W = ((CW + 33) > sle_pkg::RV_W) ? (CW + 33) : sle_pkg::RV_W;

    logic signed [31:0] mem [CAPACITY];

    logic [3:0]          op_reg;
    logic [7:0]          pos_reg;
    logic signed [31:0]  val_reg;
    logic [CW-1:0]       len_reg;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic signed [31:0]  rdata_reg;
    logic signed [31:0]  tmp_reg;
    logic signed [SUM_W-1:0] cur_reg, best_reg, sum_reg, cnt_reg;
    logic [1:0]          st_reg;
    logic signed [sle_pkg::RV_W-1:0] rv_reg;
    logic [7:0]          rp_reg;
    logic [1:0]          m_status_reg;
    logic [sle_pkg::RV_W-1:0] m_rv_reg;
    logic [7:0]          m_rp_reg;
    logic [7:0]          m_len_reg;

    logic [CMPW-1:0]     pos_ext, len_ext, i_ext, j_ext;
    logic [CW-1:0]       pos_m1, ra_full, wa_full;
    logic [AW-1:0]       raddr, waddr;
    logic signed [31:0]  wdata;
    logic signed [SUM_W-1:0] x_ext, cur_step, sum_step;

    assign pos_ext = CMPW'(pos_reg);
    assign len_ext = CMPW'(len_reg);
    assign i_ext   = CMPW'(i_reg);
    assign j_ext   = CMPW'(j_reg);
    assign pos_m1  = CW'(pos_ext - CMPW'(1));

    assign flags.op        = op_reg;
    assign flags.get_ok    = (pos_reg != 8'd0) && (pos_ext <= len_ext);
    assign flags.ins_ok    = (pos_reg != 8'd0) && (pos_ext <= len_ext + CMPW'(1));
    assign flags.full      = (len_ext >= CMPW'(CAPACITY));
    assign flags.empty     = (len_reg == '0);
    assign flags.i_lt_n    = (i_reg < len_reg);
    assign flags.i_zero    = (i_reg == '0);
    assign flags.i_p1_lt_n = (i_ext + CMPW'(1) < len_ext);
    assign flags.j_ge_pos  = (j_ext >= pos_ext);
    assign flags.j_lt_i    = (j_reg < i_reg);
    assign flags.j_lt_n    = (j_reg < len_reg);
    assign flags.j_p1_lt_n = (j_ext + CMPW'(1) < len_ext);
    assign flags.match     = (rdata_reg == val_reg);
    assign flags.swap      = (tmp_reg > rdata_reg);

    always_comb begin
        unique case (cmd.ra_sel)
            sle_pkg::RA_ZERO:   ra_full = '0;
            sle_pkg::RA_I:      ra_full = i_reg;
            sle_pkg::RA_I_M1:   ra_full = i_reg - CW'(1);
            sle_pkg::RA_I_P1:   ra_full = i_reg + CW'(1);
            sle_pkg::RA_J:      ra_full = j_reg;
            sle_pkg::RA_J_M1:   ra_full = j_reg - CW'(1);
            sle_pkg::RA_J_P1:   ra_full = j_reg + CW'(1);
            sle_pkg::RA_POS_M1: ra_full = pos_m1;
            default:            ra_full = '0;
        endcase
        unique case (cmd.wa_sel)
            sle_pkg::WA_J:      wa_full = j_reg;
            sle_pkg::WA_J_P1:   wa_full = j_reg + CW'(1);
            sle_pkg::WA_POS_M1: wa_full = pos_m1;
            default:            wa_full = j_reg;
        endcase
        unique case (cmd.wd_sel)
            sle_pkg::WD_RDATA: wdata = rdata_reg;
            sle_pkg::WD_TMP:   wdata = tmp_reg;
            sle_pkg::WD_VAL:   wdata = val_reg;
            default:           wdata = rdata_reg;
        endcase
    end

    assign raddr = ra_full[AW-1:0];
    assign waddr = wa_full[AW-1:0];

    function automatic logic [CW-1:0] cnt_next(input sle_pkg::cnt_op_t op,
                                               input logic [CW-1:0] cur,
                                               input logic [CW-1:0] n,
                                               input logic [CW-1:0] pm1,
                                               input logic [CW-1:0] iv);
        logic [CW-1:0] r;
        unique case (op)
            sle_pkg::CNT_HOLD:   r = cur;
            sle_pkg::CNT_ZERO:   r = '0;
            sle_pkg::CNT_ONE:    r = CW'(1);
            sle_pkg::CNT_INC:    r = cur + CW'(1);
            sle_pkg::CNT_DEC:    r = cur - CW'(1);
            sle_pkg::CNT_N:      r = n;
            sle_pkg::CNT_N_M1:   r = n - CW'(1);
            sle_pkg::CNT_POS_M1: r = pm1;
            sle_pkg::CNT_I:      r = iv;
            default:             r = cur;
        endcase
        return r;
    endfunction

    assign i_next = cnt_next(cmd.i_op, i_reg, len_reg, pos_m1, i_reg);
    assign j_next = cnt_next(cmd.j_op, j_reg, len_reg, pos_m1, i_reg);

    assign x_ext    = SUM_W'(rdata_reg);
    assign cur_step = (cur_reg > 0) ? (cur_reg + x_ext) : x_ext;
    assign sum_step = sum_reg + x_ext;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            unique case (cmd.len_op)
                sle_pkg::LEN_HOLD: len_reg <= len_reg;
                sle_pkg::LEN_ZERO: len_reg <= '0;
                sle_pkg::LEN_INC:  len_reg <= len_reg + CW'(1);
                sle_pkg::LEN_DEC:  len_reg <= len_reg - CW'(1);
                default:           len_reg <= len_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        if (cmd.load_cmd) begin
            op_reg  <= s_tuser;
            pos_reg <= s_tdata[7:0];
            val_reg <= s_tdata[39:8];
            st_reg  <= sle_pkg::ST_ERR;
            rv_reg  <= '0;
            rp_reg  <= '0;
        end else begin
            if (cmd.st_ld) begin
                st_reg <= cmd.st_code;
            end
            if (cmd.rv_ld) begin
                unique case (cmd.rv_sel)
                    sle_pkg::RV_RDATA: rv_reg <= sle_pkg::RV_W'(rdata_reg);
                    sle_pkg::RV_BEST:  rv_reg <= sle_pkg::RV_W'(best_reg);
                    sle_pkg::RV_CNT:   rv_reg <= sle_pkg::RV_W'(cnt_reg);
                    default:           rv_reg <= '0;
                endcase
            end
            if (cmd.rp_ld) begin
                rp_reg <= 8'(i_ext + CMPW'(1));
            end
        end
        if (cmd.tmp_ld) begin
            tmp_reg <= rdata_reg;
        end
        unique case (cmd.ar_op)
            sle_pkg::AR_NONE: begin
            end
            sle_pkg::AR_K_INIT: begin
                cur_reg  <= x_ext;
                best_reg <= x_ext;
            end
            sle_pkg::AR_K_STEP: begin
                cur_reg <= cur_step;
                if (cur_step > best_reg) begin
                    best_reg <= cur_step;
                end
            end
            sle_pkg::AR_SUM_CLR: sum_reg <= '0;
            sle_pkg::AR_SUM_ADD: begin
                sum_reg <= sum_step;
                if (sum_step == SUM_W'(val_reg)) begin
                    cnt_reg <= cnt_reg + SUM_W'(1);
                end
            end
            sle_pkg::AR_CNT_CLR: cnt_reg <= '0;
            default: begin
            end
        endcase
        if (cmd.out_ld) begin
            m_status_reg <= st_reg;
            m_rv_reg     <= rv_reg;
            m_rp_reg     <= rp_reg;
            m_len_reg    <= 8'(len_reg);
        end
    end

    assign m_tdata = {m_len_reg, m_rp_reg, m_rv_reg};
    assign m_tuser = m_status_reg;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_ext <= CMPW'(CAPACITY))
        else $error("list length above capacity");
    a_inc_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.len_op == sle_pkg::LEN_INC |-> len_ext < CMPW'(CAPACITY))
        else $error("growth of a full list");
    a_read_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> ra_full < len_reg)
        else $error("read beyond list end");
    a_write_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> wa_full <= len_reg)
        else $error("write beyond list end");
`endif

endmodule

// ===== hw/rtl/sle_controller.sv =====
`timescale 1ns / 1ps

module sle_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  sle_pkg::flags_t flags,
    output sle_pkg::cmd_t   cmd
);

    sle_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == sle_pkg::SL_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sle_pkg::SL_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_ld) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sle_pkg::SL_IDLE:
                if (s_tvalid) state_next = sle_pkg::SL_DISPATCH;
            sle_pkg::SL_DISPATCH: begin
                priority case (flags.op)
                    sle_pkg::OP_CLEAR:  state_next = sle_pkg::SL_DONE;
                    sle_pkg::OP_GET:
                        state_next = flags.get_ok ? sle_pkg::SL_GET_WAIT : sle_pkg::SL_DONE;
                    sle_pkg::OP_LOCATE, sle_pkg::OP_PRIOR, sle_pkg::OP_NEXT:
                        state_next = sle_pkg::SL_SCAN_RD;
                    sle_pkg::OP_INSERT:
                        state_next = (flags.ins_ok && !flags.full) ?
                                     sle_pkg::SL_INS_CHK : sle_pkg::SL_DONE;
                    sle_pkg::OP_DELETE:
                        state_next = flags.get_ok ? sle_pkg::SL_DEL_RES : sle_pkg::SL_DONE;
                    sle_pkg::OP_SORT:
                        state_next = flags.empty ? sle_pkg::SL_DONE : sle_pkg::SL_SORT_CHK;
                    sle_pkg::OP_MAXSUB:
                        state_next = flags.empty ? sle_pkg::SL_DONE : sle_pkg::SL_MAX_INIT;
                    sle_pkg::OP_COUNT:
                        state_next = flags.empty ? sle_pkg::SL_DONE : sle_pkg::SL_CNT_OUTER;
                    default: state_next = sle_pkg::SL_DONE;
                endcase
            end
            sle_pkg::SL_GET_WAIT: state_next = sle_pkg::SL_DONE;
            sle_pkg::SL_SCAN_RD:
                state_next = flags.i_lt_n ? sle_pkg::SL_SCAN_CMP : sle_pkg::SL_DONE;
            sle_pkg::SL_SCAN_CMP: begin
                if (!flags.match) begin
                    state_next = sle_pkg::SL_SCAN_RD;
                end else if ((flags.op == sle_pkg::OP_PRIOR && !flags.i_zero) ||
                             (flags.op == sle_pkg::OP_NEXT && flags.i_p1_lt_n)) begin
                    state_next = sle_pkg::SL_GET_WAIT;
                end else begin
                    state_next = sle_pkg::SL_DONE;
                end
            end
            sle_pkg::SL_INS_CHK:
                state_next = flags.j_ge_pos ? sle_pkg::SL_INS_WR : sle_pkg::SL_DONE;
            sle_pkg::SL_INS_WR:  state_next = sle_pkg::SL_INS_CHK;
            sle_pkg::SL_DEL_RES: state_next = sle_pkg::SL_DEL_CHK;
            sle_pkg::SL_DEL_CHK:
                state_next = flags.j_p1_lt_n ? sle_pkg::SL_DEL_WR : sle_pkg::SL_DONE;
            sle_pkg::SL_DEL_WR:  state_next = sle_pkg::SL_DEL_CHK;
            sle_pkg::SL_SORT_CHK: begin
                priority if (flags.i_zero) state_next = sle_pkg::SL_DONE;
                else if (flags.j_lt_i)     state_next = sle_pkg::SL_SORT_RD1;
                else                       state_next = sle_pkg::SL_SORT_CHK;
            end
            sle_pkg::SL_SORT_RD1: state_next = sle_pkg::SL_SORT_CMP;
            sle_pkg::SL_SORT_CMP:
                state_next = flags.swap ? sle_pkg::SL_SORT_WR : sle_pkg::SL_SORT_CHK;
            sle_pkg::SL_SORT_WR:  state_next = sle_pkg::SL_SORT_CHK;
            sle_pkg::SL_MAX_INIT: state_next = sle_pkg::SL_MAX_RD;
            sle_pkg::SL_MAX_RD:
                state_next = flags.i_lt_n ? sle_pkg::SL_MAX_STEP : sle_pkg::SL_DONE;
            sle_pkg::SL_MAX_STEP: state_next = sle_pkg::SL_MAX_RD;
            sle_pkg::SL_CNT_OUTER:
                state_next = flags.i_lt_n ? sle_pkg::SL_CNT_RD : sle_pkg::SL_DONE;
            sle_pkg::SL_CNT_RD:
                state_next = flags.j_lt_n ? sle_pkg::SL_CNT_ADD : sle_pkg::SL_CNT_OUTER;
            sle_pkg::SL_CNT_ADD: state_next = sle_pkg::SL_CNT_RD;
            sle_pkg::SL_DONE:
                if (out_free) state_next = sle_pkg::SL_IDLE;
            default: state_next = sle_pkg::SL_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.i_op    = sle_pkg::CNT_HOLD;
        cmd.j_op    = sle_pkg::CNT_HOLD;
        cmd.ra_sel  = sle_pkg::RA_ZERO;
        cmd.wa_sel  = sle_pkg::WA_J;
        cmd.wd_sel  = sle_pkg::WD_RDATA;
        cmd.ar_op   = sle_pkg::AR_NONE;
        cmd.len_op  = sle_pkg::LEN_HOLD;
        cmd.st_code = sle_pkg::ST_OK;
        cmd.rv_sel  = sle_pkg::RV_RDATA;
        unique case (state_reg)
            sle_pkg::SL_IDLE:
                cmd.load_cmd = s_tvalid;
            sle_pkg::SL_DISPATCH: begin
                priority case (flags.op)
                    sle_pkg::OP_CLEAR: begin
                        cmd.len_op = sle_pkg::LEN_ZERO;
                        cmd.st_ld  = 1'b1;
                    end
                    sle_pkg::OP_GET: begin
                        cmd.rd_en  = flags.get_ok;
                        cmd.ra_sel = sle_pkg::RA_POS_M1;
                    end
                    sle_pkg::OP_LOCATE, sle_pkg::OP_PRIOR, sle_pkg::OP_NEXT:
                        cmd.i_op = sle_pkg::CNT_ZERO;
                    sle_pkg::OP_INSERT: begin
                        cmd.j_op    = sle_pkg::CNT_N;
                        cmd.st_ld   = flags.ins_ok && flags.full;
                        cmd.st_code = sle_pkg::ST_FULL;
                    end
                    sle_pkg::OP_DELETE: begin
                        cmd.rd_en  = flags.get_ok;
                        cmd.ra_sel = sle_pkg::RA_POS_M1;
                        cmd.j_op   = sle_pkg::CNT_POS_M1;
                    end
                    sle_pkg::OP_SORT: begin
                        cmd.i_op = sle_pkg::CNT_N_M1;
                        cmd.j_op = sle_pkg::CNT_ZERO;
                    end
                    sle_pkg::OP_MAXSUB: begin
                        cmd.rd_en  = !flags.empty;
                        cmd.ra_sel = sle_pkg::RA_ZERO;
                        cmd.i_op   = sle_pkg::CNT_ONE;
                    end
                    sle_pkg::OP_COUNT: begin
                        cmd.i_op  = sle_pkg::CNT_ZERO;
                        cmd.ar_op = sle_pkg::AR_CNT_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            sle_pkg::SL_GET_WAIT: begin
                cmd.rv_ld = 1'b1;
                cmd.st_ld = 1'b1;
            end
            sle_pkg::SL_SCAN_RD: begin
                cmd.rd_en  = flags.i_lt_n;
                cmd.ra_sel = sle_pkg::RA_I;
            end
            sle_pkg::SL_SCAN_CMP: begin
                if (!flags.match) begin
                    cmd.i_op = sle_pkg::CNT_INC;
                end else if (flags.op == sle_pkg::OP_LOCATE) begin
                    cmd.rp_ld = 1'b1;
                    cmd.st_ld = 1'b1;
                end else if (flags.op == sle_pkg::OP_PRIOR) begin
                    cmd.rd_en  = !flags.i_zero;
                    cmd.ra_sel = sle_pkg::RA_I_M1;
                end else begin
                    cmd.rd_en  = flags.i_p1_lt_n;
                    cmd.ra_sel = sle_pkg::RA_I_P1;
                end
            end
            sle_pkg::SL_INS_CHK: begin
                if (flags.j_ge_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = sle_pkg::RA_J_M1;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = sle_pkg::WA_POS_M1;
                    cmd.wd_sel = sle_pkg::WD_VAL;
                    cmd.len_op = sle_pkg::LEN_INC;
                    cmd.st_ld  = 1'b1;
                end
            end
            sle_pkg::SL_INS_WR: begin
                cmd.wr_en = 1'b1;
                cmd.j_op  = sle_pkg::CNT_DEC;
            end
            sle_pkg::SL_DEL_RES:
                cmd.rv_ld = 1'b1;
            sle_pkg::SL_DEL_CHK: begin
                if (flags.j_p1_lt_n) begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = sle_pkg::RA_J_P1;
                end else begin
                    cmd.len_op = sle_pkg::LEN_DEC;
                    cmd.st_ld  = 1'b1;
                end
            end
            sle_pkg::SL_DEL_WR: begin
                cmd.wr_en = 1'b1;
                cmd.j_op  = sle_pkg::CNT_INC;
            end
            sle_pkg::SL_SORT_CHK: begin
                priority if (flags.i_zero) begin
                    cmd.st_ld = 1'b1;
                end else if (flags.j_lt_i) begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = sle_pkg::RA_J;
                end else begin
                    cmd.i_op = sle_pkg::CNT_DEC;
                    cmd.j_op = sle_pkg::CNT_ZERO;
                end
            end
            sle_pkg::SL_SORT_RD1: begin
                cmd.tmp_ld = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.ra_sel = sle_pkg::RA_J_P1;
            end
            sle_pkg::SL_SORT_CMP: begin
                if (flags.swap) begin
                    cmd.wr_en = 1'b1;
                end else begin
                    cmd.j_op = sle_pkg::CNT_INC;
                end
            end
            sle_pkg::SL_SORT_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = sle_pkg::WA_J_P1;
                cmd.wd_sel = sle_pkg::WD_TMP;
                cmd.j_op   = sle_pkg::CNT_INC;
            end
            sle_pkg::SL_MAX_INIT:
                cmd.ar_op = sle_pkg::AR_K_INIT;
            sle_pkg::SL_MAX_RD: begin
                if (flags.i_lt_n) begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = sle_pkg::RA_I;
                end else begin
                    cmd.rv_ld  = 1'b1;
                    cmd.rv_sel = sle_pkg::RV_BEST;
                    cmd.st_ld  = 1'b1;
                end
            end
            sle_pkg::SL_MAX_STEP: begin
                cmd.ar_op = sle_pkg::AR_K_STEP;
                cmd.i_op  = sle_pkg::CNT_INC;
            end
            sle_pkg::SL_CNT_OUTER: begin
                if (flags.i_lt_n) begin
                    cmd.j_op  = sle_pkg::CNT_I;
                    cmd.ar_op = sle_pkg::AR_SUM_CLR;
                end else begin
                    cmd.rv_ld  = 1'b1;
                    cmd.rv_sel = sle_pkg::RV_CNT;
                    cmd.st_ld  = 1'b1;
                end
            end
            sle_pkg::SL_CNT_RD: begin
                if (flags.j_lt_n) begin
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = sle_pkg::RA_J;
                end else begin
                    cmd.i_op = sle_pkg::CNT_INC;
                end
            end
            sle_pkg::SL_CNT_ADD: begin
                cmd.ar_op = sle_pkg::AR_SUM_ADD;
                cmd.j_op  = sle_pkg::CNT_INC;
            end
            sle_pkg::SL_DONE:
                cmd.out_ld = out_free;
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == sle_pkg::SL_DISPATCH)
        else $error("accepted transaction not dispatched");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !cmd.out_ld)
        else $error("pending result overwritten");
    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("read and write in one cycle");
`endif

endmodule

// ===== hw/rtl/sequential_list_engine_unit.sv =====
`timescale 1ns / 1ps

// Ordered list of signed 32-bit elements held in a single-port store of CAPACITY entries
// with registered read; one command transaction gives exactly one result transaction.
// The store serves one read or one write per cycle, so run time grows with the work: locate,
// prior and next read each element scanned, insert and delete move each element shifted,
// max-subarray reads each element, sort compares and may swap each of n(n-1)/2 pairs, and
// subarray count reads one element per pair of start and end. A new command is taken once
// the previous one has finished and its result sits in the output register; the store needs
// no clearing after reset.
module sequential_list_engine_unit #(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
    input  logic [3:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // result_value[39:0], result_position[47:40], list_size[55:48]
    output logic [1:0]  m_tuser    // status
);

    sle_pkg::cmd_t   cmd;
    sle_pkg::flags_t flags;

    sle_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .flags   (flags),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
